>>> hw/rtl/fan_and_compressor_hysteresis_control_macros.svh
// Assertion macros used by the checker file of the cooling controller.
`ifndef FAN_AND_COMPRESSOR_HYSTERESIS_CONTROL_MACROS_SVH
`define FAN_AND_COMPRESSOR_HYSTERESIS_CONTROL_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define FACHC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define FACHC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/fachc_pkg.sv
// Types and constants of the fan and compressor hysteresis controller.
`default_nettype none

package fachc_pkg;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    localparam logic signed [7:0] TEMP_TOP = 8'sd120;
    localparam logic [8:0] PRESS_TOP = 9'd310;

    localparam logic signed [7:0] RST_TEMP_S1_ON = 8'sd100;
    localparam logic signed [7:0] RST_TEMP_S1_OFF = 8'sd92;
    localparam logic signed [7:0] RST_TEMP_S2_ON = 8'sd106;
    localparam logic [8:0] RST_PRESS_S1_ON = 9'd130;
    localparam logic [8:0] RST_PRESS_S1_KEEP = 9'd210;
    localparam logic [8:0] RST_PRESS_S2_ON = 9'd220;
    localparam logic [8:0] RST_PRESS_LOW_CUT = 9'd40;
    localparam logic [8:0] RST_PRESS_HIGH_CUT = 9'd280;

    typedef enum logic [2:0] {
        REG_TEMP_S1_ON = 3'd0,
        REG_TEMP_S1_OFF = 3'd1,
        REG_TEMP_S2_ON = 3'd2,
        REG_PRESS_S1_ON = 3'd3,
        REG_PRESS_S1_KEEP = 3'd4,
        REG_PRESS_S2_ON = 3'd5,
        REG_PRESS_LOW_CUT = 3'd6,
        REG_PRESS_HIGH_CUT = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FAN_OFF = 2'd0,
        FAN_LOW = 2'd1,
        FAN_HIGH = 2'd2
    } fan_stage_t;

    typedef struct packed {
        logic [9:0] coolant_sample;
        logic [9:0] pressure_sample;
        logic       ac_request;
    } tick_t;

    typedef struct packed {
        logic              fan_low;
        logic              fan_high;
        logic              compressor;
        logic signed [7:0] coolant_temp;
        logic [8:0]        pressure;
    } result_t;

    // Averaging window status handed to the fan logic.
    typedef struct packed {
        logic              done;
        logic signed [7:0] temp;
    } avg_t;

endpackage

`default_nettype wire

>>> hw/rtl/fachc_temp_avg.sv
// Coolant sample accumulator, average and temperature mapping.
`default_nettype none

module fachc_temp_avg #(
    parameter int SAMPLES = 10
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  wire logic [9:0]      coolant_sample,
    output fachc_pkg::avg_t      avg
);

    localparam int CNT_W = $clog2(SAMPLES + 1);
    localparam int SUM_W = $clog2(SAMPLES * 1023 + 1);
    localparam int SH_L = $clog2(SAMPLES);
    localparam int SHIFT = SUM_W + SH_L;
    localparam int MUL_W = SUM_W + 1;
    localparam longint unsigned MUL_K =
        ((64'd1 << SHIFT) + SAMPLES - 1) / SAMPLES;

    logic [CNT_W-1:0]       count_reg, count_next;
    logic [SUM_W-1:0]       sum_reg, sum_next, sum_total;
    logic [SUM_W+MUL_W-1:0] quot_prod;
    logic [9:0]             mean;
    logic [17:0]            scaled;
    logic signed [8:0]      temp_wide;
    logic                   done;

    always_comb
    begin
        count_next = count_reg + CNT_W'(1);
        sum_total = sum_reg + SUM_W'(coolant_sample);
        done = (count_next >= CNT_W'(SAMPLES));
        // exact floor division by reciprocal multiply
        quot_prod = (SUM_W+MUL_W)'(sum_total) * (SUM_W+MUL_W)'(MUL_W'(MUL_K));
        mean = 10'(quot_prod >> SHIFT);
        // mean * 130 as two shifted terms
        scaled = {1'b0, mean, 7'b0} + {7'b0, mean, 1'b0};
        temp_wide = 9'sd120 - $signed({1'b0, scaled[17:10]});
        avg.done = done;
        avg.temp = temp_wide[7:0];
        sum_next = done ? '0 : sum_total;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg <= '0;
        end
        else if (advance)
        begin
            count_reg <= done ? '0 : count_next;
            sum_reg <= sum_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/fan_and_compressor_hysteresis_control.sv
// Top level of the radiator fan and A/C compressor hysteresis controller.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------
//  tick     | tick_valid / tick_ready   | fachc_pkg::tick_t (two samples, request)
//  result   | result_valid/result_ready | fachc_pkg::result_t (fans, clutch, values)
//  config   | APB psel/penable/pwrite   | paddr[4:2] selects one of eight thresholds
//
// One tick transaction is taken every cycle while no held result stalls the
// input register; its result goes through the input register, then the result
// register, to the result port. Each tick takes a single pass of the
// combinational logic between those two registers.
// Reset clears the valid flags and controller state and loads the threshold defaults.
// A held result stalls the input register, and that stalls the tick channel.
`default_nettype none

module fan_and_compressor_hysteresis_control #(
    parameter int SAMPLES = 10,
    parameter int TICKS_PER_SECOND = 4,
    parameter int REST_SECONDS = 5
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          tick_valid,
    output logic                               tick_ready,
    input  wire fachc_pkg::tick_t              tick,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output fachc_pkg::result_t                 result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fachc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [fachc_pkg::DATA_W-1:0]  pwdata,
    output logic [fachc_pkg::DATA_W-1:0]       prdata,
    output logic                               pready
);

    localparam int DIV_W = $clog2(TICKS_PER_SECOND + 1);
    localparam int REST_W = (REST_SECONDS < 1) ? 1 : $clog2(REST_SECONDS + 1);

    // Threshold registers.
    logic signed [7:0] temp_s1_on_reg, temp_s1_off_reg, temp_s2_on_reg;
    logic [8:0]        press_s1_on_reg, press_s1_keep_reg, press_s2_on_reg;
    logic [8:0]        press_low_cut_reg, press_high_cut_reg;

    // Pipeline registers.
    logic               in_valid_reg;
    fachc_pkg::tick_t   in_data_reg;
    logic               out_valid_reg;
    fachc_pkg::result_t out_data_reg, out_data_next;
    logic               advance;

    // Controller state.
    logic signed [7:0]      temp_value_reg, temp_value_next;
    fachc_pkg::fan_stage_t  fan_stage_reg, fan_stage_next;
    logic [8:0]             press_value_reg, press_value_next;
    logic [DIV_W-1:0]       tick_div_reg, tick_div_next;
    logic [REST_W-1:0]      rest_timer_reg, rest_timer_next;
    logic                   comp_reg, comp_next;

    fachc_pkg::avg_t   avg;
    fachc_pkg::cfg_reg_t cfg_sel;
    logic [18:0]       press_prod;
    logic              second_tick, in_band, cut;

    assign pready = 1'b1;
    assign cfg_sel = fachc_pkg::cfg_reg_t'(paddr[4:2]);

    // Configuration writes: take on the access phase of an APB write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_s1_on_reg <= fachc_pkg::RST_TEMP_S1_ON;
            temp_s1_off_reg <= fachc_pkg::RST_TEMP_S1_OFF;
            temp_s2_on_reg <= fachc_pkg::RST_TEMP_S2_ON;
            press_s1_on_reg <= fachc_pkg::RST_PRESS_S1_ON;
            press_s1_keep_reg <= fachc_pkg::RST_PRESS_S1_KEEP;
            press_s2_on_reg <= fachc_pkg::RST_PRESS_S2_ON;
            press_low_cut_reg <= fachc_pkg::RST_PRESS_LOW_CUT;
            press_high_cut_reg <= fachc_pkg::RST_PRESS_HIGH_CUT;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (cfg_sel)
                fachc_pkg::REG_TEMP_S1_ON:     temp_s1_on_reg <= pwdata[7:0];
                fachc_pkg::REG_TEMP_S1_OFF:    temp_s1_off_reg <= pwdata[7:0];
                fachc_pkg::REG_TEMP_S2_ON:     temp_s2_on_reg <= pwdata[7:0];
                fachc_pkg::REG_PRESS_S1_ON:    press_s1_on_reg <= pwdata[8:0];
                fachc_pkg::REG_PRESS_S1_KEEP:  press_s1_keep_reg <= pwdata[8:0];
                fachc_pkg::REG_PRESS_S2_ON:    press_s2_on_reg <= pwdata[8:0];
                fachc_pkg::REG_PRESS_LOW_CUT:  press_low_cut_reg <= pwdata[8:0];
                fachc_pkg::REG_PRESS_HIGH_CUT: press_high_cut_reg <= pwdata[8:0];
            endcase
        end
    end

    // Read back: sign-extend the temperature thresholds.
    always_comb
    begin
        unique case (cfg_sel)
            fachc_pkg::REG_TEMP_S1_ON:     prdata = 32'(temp_s1_on_reg);
            fachc_pkg::REG_TEMP_S1_OFF:    prdata = 32'(temp_s1_off_reg);
            fachc_pkg::REG_TEMP_S2_ON:     prdata = 32'(temp_s2_on_reg);
            fachc_pkg::REG_PRESS_S1_ON:    prdata = {23'b0, press_s1_on_reg};
            fachc_pkg::REG_PRESS_S1_KEEP:  prdata = {23'b0, press_s1_keep_reg};
            fachc_pkg::REG_PRESS_S2_ON:    prdata = {23'b0, press_s2_on_reg};
            fachc_pkg::REG_PRESS_LOW_CUT:  prdata = {23'b0, press_low_cut_reg};
            fachc_pkg::REG_PRESS_HIGH_CUT: prdata = {23'b0, press_high_cut_reg};
        endcase
    end

    // Advance the input register into the result register when the result is free.
    assign advance = in_valid_reg && (!out_valid_reg || result_ready);
    assign tick_ready = !in_valid_reg || advance;
    assign result_valid = out_valid_reg;
    assign result = out_data_reg;

    fachc_temp_avg #(
        .SAMPLES(SAMPLES)
    ) u_temp_avg (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .coolant_sample(in_data_reg.coolant_sample),
        .avg           (avg)
    );

    always_comb
    begin
        // Fan hysteresis runs only when an average completes; it sees the
        // pressure of the previous tick. Later rules override earlier ones.
        temp_value_next = temp_value_reg;
        fan_stage_next = fan_stage_reg;
        if (avg.done)
        begin
            temp_value_next = avg.temp;
            if (avg.temp >= temp_s1_on_reg || press_value_reg >= press_s1_on_reg)
                fan_stage_next = fachc_pkg::FAN_LOW;
            if (avg.temp >= temp_s2_on_reg || press_value_reg >= press_s2_on_reg)
                fan_stage_next = fachc_pkg::FAN_HIGH;
            if (fan_stage_next == fachc_pkg::FAN_HIGH && avg.temp <= temp_s1_on_reg
                    && press_value_reg <= press_s1_keep_reg)
                fan_stage_next = fachc_pkg::FAN_LOW;
            if (fan_stage_next != fachc_pkg::FAN_OFF && avg.temp <= temp_s1_off_reg
                    && press_value_reg < press_s1_on_reg)
                fan_stage_next = fachc_pkg::FAN_OFF;
        end

        // Pressure map: 310 - floor(s * 310 / 1024).
        press_prod = 19'(in_data_reg.pressure_sample) * 19'(fachc_pkg::PRESS_TOP);
        press_value_next = fachc_pkg::PRESS_TOP - press_prod[18:10];

        // Once-per-second compressor logic on the fresh pressure and request.
        tick_div_next = tick_div_reg + DIV_W'(1);
        second_tick = (tick_div_next >= DIV_W'(TICKS_PER_SECOND));
        in_band = (press_value_next <= press_high_cut_reg)
            && (press_value_next > press_low_cut_reg);
        cut = (press_value_next >= press_high_cut_reg)
            || (press_value_next < press_low_cut_reg) || !in_data_reg.ac_request;
        comp_next = comp_reg;
        rest_timer_next = rest_timer_reg;
        if (second_tick)
        begin
            tick_div_next = '0;
            if (in_band && in_data_reg.ac_request && !comp_reg
                    && rest_timer_reg == REST_W'(REST_SECONDS))
                comp_next = 1'b1;
            if (cut && comp_next)
            begin
                comp_next = 1'b0;
                rest_timer_next = '0;
            end
            if (rest_timer_next < REST_W'(REST_SECONDS))
                rest_timer_next = rest_timer_next + REST_W'(1);
        end

        out_data_next.fan_low = (fan_stage_next == fachc_pkg::FAN_LOW);
        out_data_next.fan_high = (fan_stage_next == fachc_pkg::FAN_HIGH);
        out_data_next.compressor = comp_next;
        out_data_next.coolant_temp = temp_value_next;
        out_data_next.pressure = press_value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            temp_value_reg <= '0;
            fan_stage_reg <= fachc_pkg::FAN_OFF;
            press_value_reg <= '0;
            tick_div_reg <= '0;
            rest_timer_reg <= '0;
            comp_reg <= 1'b0;
        end
        else
        begin
            if (tick_ready)
                in_valid_reg <= tick_valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                temp_value_reg <= temp_value_next;
                fan_stage_reg <= fan_stage_next;
                press_value_reg <= press_value_next;
                tick_div_reg <= tick_div_next;
                rest_timer_reg <= rest_timer_next;
                comp_reg <= comp_next;
            end
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers: load without reset.
    always_ff @(posedge clk)
    begin
        if (tick_valid && tick_ready)
            in_data_reg <= tick;
        if (advance)
            out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/fachc_checker.sv
// Port-level checker for the cooling controller, bound to the top level.
`default_nettype none
`include "fan_and_compressor_hysteresis_control_macros.svh"

module fachc_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               result_valid,
    input wire logic               result_ready,
    input wire fachc_pkg::result_t result
);

    `FACHC_ASSERT_NOW(a_fans_exclusive, clk, rst_n, result_valid, !(result.fan_low && result.fan_high), "both fan stages driven")
    `FACHC_ASSERT_NOW(a_press_range, clk, rst_n, result_valid, result.pressure <= fachc_pkg::PRESS_TOP, "pressure above range")
    `FACHC_ASSERT_NOW(a_temp_range, clk, rst_n, result_valid, (result.coolant_temp <= fachc_pkg::TEMP_TOP) && (result.coolant_temp >= -8'sd10), "coolant temperature out of range")
    `FACHC_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result), "stalled result changed")

endmodule

bind fan_and_compressor_hysteresis_control fachc_checker u_fachc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
);

`default_nettype wire
